>>> sv/dual_key_refcounted_table_defines.svh
// Assertion macros used by the checker file.
`ifndef DUAL_KEY_REFCOUNTED_TABLE_DEFINES_SVH
`define DUAL_KEY_REFCOUNTED_TABLE_DEFINES_SVH

// Same-cycle implication, ignored while reset is asserted.
`define DKRT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("dkrt check failed");

// Next-cycle implication, ignored while reset is asserted.
`define DKRT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("dkrt check failed");

// Next-cycle implication that also holds through reset.
`define DKRT_ASSERT_ALWAYS(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("dkrt check failed");

`endif

>>> sv/dkrt_pkg.sv
package dkrt_pkg;

    localparam int REFCNT_W = 2;

    typedef enum logic [2:0] {
        REQ_INSERT     = 3'd0,
        REQ_ERASE_PRI  = 3'd1,
        REQ_READ_PRI   = 3'd2,
        REQ_WRITE_PRI  = 3'd3,
        REQ_READ_SEC   = 3'd4,
        REQ_WRITE_SEC  = 3'd5
    } req_e_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_NOT_FOUND  = 2'd1,
        STAT_BAD_INSERT = 2'd2,
        STAT_NO_SLOT    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SLOT_RD,
        ST_DONE
    } state_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] read_value;
    } result_t;

endpackage

>>> sv/dual_key_refcounted_table.sv
// Channel   Direction  Ports                         Contents
// request   in         s_tvalid s_tready s_tdata     keys, present flags, value
//                      s_tuser                       request type
// result    out        m_tvalid m_tready m_tdata     read value
//                      m_tuser                       status
//
// Each accepted request is handled in order: a linear scan of the three
// memories, one address per cycle through their single ports; a decision step;
// a slot access step when a key hit needs one (not for an insert, a key miss
// or an unused request type); then the result. The sequencer takes the next
// request in the cycle after it hands its result to the output register.
// After reset a clearing pass writes every memory entry to zero, with s_tready low.
// A stalled result sits in the output register while the next request is taken.
module dual_key_refcounted_table #(
    parameter int SLOTS             = 16,
    parameter int PRIMARY_ENTRIES   = 16,
    parameter int SECONDARY_ENTRIES = 16,
    parameter int KEY_BITS          = 32,
    parameter int VALUE_BITS        = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [31:0] primary_key, [32] primary_present, [64:33] secondary_key,
    // [65] secondary_present, [97:66] new_value, [103:98] zero
    input  logic [103:0] s_tdata,
    // [2:0] req_type
    input  logic [2:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] read_value
    output logic [31:0]  m_tdata,
    // [1:0] status
    output logic [1:0]   m_tuser
);
    import dkrt_pkg::*;

    localparam int SW = $clog2(SLOTS);
    localparam int IW = KEY_BITS + SW + 1;
    localparam int DW = REFCNT_W + VALUE_BITS;

    // Keys and values are kept at their configured widths; the incoming
    // 32-bit fields are truncated or zero-extended to fit.
    logic [KEY_BITS-1:0]   pkey, skey;
    logic [VALUE_BITS-1:0] nval;

    assign pkey = KEY_BITS'(s_tdata[31:0]);
    assign skey = KEY_BITS'(s_tdata[64:33]);
    assign nval = VALUE_BITS'(s_tdata[97:66]);

    logic [$clog2(PRIMARY_ENTRIES)-1:0]   pri_addr;
    logic [$clog2(SECONDARY_ENTRIES)-1:0] sec_addr;
    logic [SW-1:0]                        slot_addr;
    logic                                 pri_we, sec_we, slot_we;
    logic [IW-1:0]                        pri_wdata, pri_rdata, sec_wdata, sec_rdata;
    logic [DW-1:0]                        slot_wdata, slot_rdata;

    logic    res_valid, res_ready;
    result_t res;

    // Primary index: used flag, slot number and tag per entry.
    dkrt_ram #(.WIDTH(IW), .DEPTH(PRIMARY_ENTRIES)) u_pri_ram (
        .clk(aclk), .addr(pri_addr), .we(pri_we), .wdata(pri_wdata), .rdata(pri_rdata)
    );

    // Secondary index, same layout as the primary one.
    dkrt_ram #(.WIDTH(IW), .DEPTH(SECONDARY_ENTRIES)) u_sec_ram (
        .clk(aclk), .addr(sec_addr), .we(sec_we), .wdata(sec_wdata), .rdata(sec_rdata)
    );

    // Slot store: reference count above the stored value.
    dkrt_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_slot_ram (
        .clk(aclk), .addr(slot_addr), .we(slot_we), .wdata(slot_wdata),
        .rdata(slot_rdata)
    );

    // The sequencer scans all three memories in step, then performs the
    // slot and index reads and writes that the request calls for.
    dkrt_ctrl #(
        .SLOTS(SLOTS), .PRIMARY_ENTRIES(PRIMARY_ENTRIES),
        .SECONDARY_ENTRIES(SECONDARY_ENTRIES), .KEY_BITS(KEY_BITS),
        .VALUE_BITS(VALUE_BITS)
    ) u_ctrl (
        .clk(aclk), .rst_n(aresetn),
        .req_valid(s_tvalid), .req_ready(s_tready),
        .req_type(s_tuser), .pkey(pkey), .ppres(s_tdata[32]),
        .skey(skey), .spres(s_tdata[65]), .nval(nval),
        .pri_addr(pri_addr), .pri_we(pri_we), .pri_wdata(pri_wdata),
        .pri_rdata(pri_rdata),
        .sec_addr(sec_addr), .sec_we(sec_we), .sec_wdata(sec_wdata),
        .sec_rdata(sec_rdata),
        .slot_addr(slot_addr), .slot_we(slot_we), .slot_wdata(slot_wdata),
        .slot_rdata(slot_rdata),
        .res_valid(res_valid), .res_ready(res_ready), .res(res)
    );

    // Output register: the sequencer hands over a result whenever the
    // register is empty or being drained in the same cycle.
    logic    m_tvalid_reg;
    result_t m_res_reg;

    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (res_ready) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            m_res_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_res_reg.read_value;
    assign m_tuser  = m_res_reg.status;
endmodule

>>> sv/dkrt_ram.sv
module dkrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic                     we,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;
endmodule

>>> sv/dkrt_ctrl.sv
module dkrt_ctrl #(
    parameter int SLOTS             = 16,
    parameter int PRIMARY_ENTRIES   = 16,
    parameter int SECONDARY_ENTRIES = 16,
    parameter int KEY_BITS          = 32,
    parameter int VALUE_BITS        = 32
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        req_valid,
    output logic                                        req_ready,
    input  logic [2:0]                                  req_type,
    input  logic [KEY_BITS-1:0]                         pkey,
    input  logic                                        ppres,
    input  logic [KEY_BITS-1:0]                         skey,
    input  logic                                        spres,
    input  logic [VALUE_BITS-1:0]                       nval,
    output logic [$clog2(PRIMARY_ENTRIES)-1:0]          pri_addr,
    output logic                                        pri_we,
    output logic [KEY_BITS+$clog2(SLOTS):0]             pri_wdata,
    input  logic [KEY_BITS+$clog2(SLOTS):0]             pri_rdata,
    output logic [$clog2(SECONDARY_ENTRIES)-1:0]        sec_addr,
    output logic                                        sec_we,
    output logic [KEY_BITS+$clog2(SLOTS):0]             sec_wdata,
    input  logic [KEY_BITS+$clog2(SLOTS):0]             sec_rdata,
    output logic [$clog2(SLOTS)-1:0]                    slot_addr,
    output logic                                        slot_we,
    output logic [dkrt_pkg::REFCNT_W+VALUE_BITS-1:0]    slot_wdata,
    input  logic [dkrt_pkg::REFCNT_W+VALUE_BITS-1:0]    slot_rdata,
    output logic                                        res_valid,
    input  logic                                        res_ready,
    output dkrt_pkg::result_t                           res
);
    import dkrt_pkg::*;

    localparam int SW   = $clog2(SLOTS);
    localparam int PW   = $clog2(PRIMARY_ENTRIES);
    localparam int QW   = $clog2(SECONDARY_ENTRIES);
    localparam int IW   = KEY_BITS + SW + 1;
    localparam int DMAX = (SLOTS > PRIMARY_ENTRIES) ?
                          ((SLOTS > SECONDARY_ENTRIES) ? SLOTS : SECONDARY_ENTRIES) :
                          ((PRIMARY_ENTRIES > SECONDARY_ENTRIES) ?
                           PRIMARY_ENTRIES : SECONDARY_ENTRIES);
    localparam int CW   = $clog2(DMAX + 1);

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] rd_idx_reg;
    logic          rd_vld_reg;

    logic [2:0]            type_reg;
    logic [KEY_BITS-1:0]   pkey_reg, skey_reg;
    logic                  ppres_reg, spres_reg;
    logic [VALUE_BITS-1:0] nval_reg;

    logic          p_hit_reg, pe_ok_reg, s_hit_reg, se_ok_reg, fs_ok_reg;
    logic [PW-1:0] p_ent_reg, pe_ent_reg;
    logic [QW-1:0] se_ent_reg;
    logic [SW-1:0] p_slot_reg, s_slot_reg, fs_reg, tgt_slot_reg;

    status_t               status_reg, status_dec;
    logic [VALUE_BITS-1:0] value_reg;

    // Fields of the words read back during the scan.
    logic                pri_used, sec_used;
    logic [KEY_BITS-1:0] pri_tag, sec_tag;
    logic [SW-1:0]       pri_slot, sec_slot;
    logic [REFCNT_W-1:0] slot_rc;

    assign pri_used = pri_rdata[IW-1];
    assign pri_slot = pri_rdata[KEY_BITS +: SW];
    assign pri_tag  = pri_rdata[KEY_BITS-1:0];
    assign sec_used = sec_rdata[IW-1];
    assign sec_slot = sec_rdata[KEY_BITS +: SW];
    assign sec_tag  = sec_rdata[KEY_BITS-1:0];
    assign slot_rc  = slot_rdata[VALUE_BITS +: REFCNT_W];

    // Decision made once the scan is complete.
    logic ins_ok, need_slot_rd;
    logic [REFCNT_W-1:0] ins_rc;

    assign ins_rc = REFCNT_W'({1'b0, ppres_reg}) + REFCNT_W'({1'b0, spres_reg});

    always_comb begin
        status_dec   = STAT_OK;
        ins_ok       = 1'b0;
        need_slot_rd = 1'b0;
        unique case (type_reg)
            REQ_INSERT: begin
                if (!ppres_reg && !spres_reg) begin
                    status_dec = STAT_BAD_INSERT;
                end else if ((ppres_reg && p_hit_reg) || (spres_reg && s_hit_reg)) begin
                    status_dec = STAT_BAD_INSERT;
                end else if (!fs_ok_reg || (ppres_reg && !pe_ok_reg) ||
                             (spres_reg && !se_ok_reg)) begin
                    status_dec = STAT_NO_SLOT;
                end else begin
                    ins_ok = 1'b1;
                end
            end
            REQ_ERASE_PRI, REQ_READ_PRI, REQ_WRITE_PRI: begin
                if (!p_hit_reg) begin
                    status_dec = STAT_NOT_FOUND;
                end else begin
                    need_slot_rd = 1'b1;
                end
            end
            REQ_READ_SEC, REQ_WRITE_SEC: begin
                if (!s_hit_reg) begin
                    status_dec = STAT_NOT_FOUND;
                end else begin
                    need_slot_rd = 1'b1;
                end
            end
            default: begin
                status_dec = STAT_OK;
            end
        endcase
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (cnt_reg == CW'(DMAX - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (req_valid) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cnt_reg == CW'(DMAX)) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                state_next = need_slot_rd ? ST_SLOT_RD : ST_DONE;
            end
            ST_SLOT_RD: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Memory ports and handshakes.
    always_comb begin
        req_ready  = 1'b0;
        res_valid  = 1'b0;
        pri_addr   = cnt_reg[PW-1:0];
        sec_addr   = cnt_reg[QW-1:0];
        slot_addr  = cnt_reg[SW-1:0];
        pri_we     = 1'b0;
        sec_we     = 1'b0;
        slot_we    = 1'b0;
        pri_wdata  = '0;
        sec_wdata  = '0;
        slot_wdata = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                pri_we  = 1'b1;
                sec_we  = 1'b1;
                slot_we = 1'b1;
            end
            ST_IDLE: begin
                req_ready = 1'b1;
            end
            ST_SCAN: begin
            end
            ST_DECIDE: begin
                if (ins_ok) begin
                    slot_addr  = fs_reg;
                    slot_we    = 1'b1;
                    slot_wdata = {ins_rc, nval_reg};
                    pri_addr   = pe_ent_reg;
                    pri_we     = ppres_reg;
                    pri_wdata  = {1'b1, fs_reg, pkey_reg};
                    sec_addr   = se_ent_reg;
                    sec_we     = spres_reg;
                    sec_wdata  = {1'b1, fs_reg, skey_reg};
                end else if (need_slot_rd) begin
                    if (type_reg == REQ_READ_SEC || type_reg == REQ_WRITE_SEC) begin
                        slot_addr = s_slot_reg;
                    end else begin
                        slot_addr = p_slot_reg;
                    end
                    if (type_reg == REQ_ERASE_PRI) begin
                        pri_addr = p_ent_reg;
                        pri_we   = 1'b1;
                    end
                end
            end
            ST_SLOT_RD: begin
                slot_addr = tgt_slot_reg;
                if (type_reg == REQ_ERASE_PRI) begin
                    slot_we    = 1'b1;
                    slot_wdata = {(slot_rc != '0) ? slot_rc - 1'b1 : slot_rc,
                                  slot_rdata[VALUE_BITS-1:0]};
                end else if (type_reg == REQ_WRITE_PRI || type_reg == REQ_WRITE_SEC) begin
                    slot_we    = 1'b1;
                    slot_wdata = {slot_rc, nval_reg};
                end
            end
            ST_DONE: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk) begin
        if (!rst_n) begin
            state_reg  <= ST_CLEAR;
            cnt_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                cnt_reg <= (state_next == ST_IDLE) ? '0 : cnt_reg + 1'b1;
            end else if (state_reg == ST_SCAN) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else begin
                cnt_reg <= '0;
            end
            rd_vld_reg <= (state_reg == ST_SCAN) && (cnt_reg < CW'(DMAX));
        end
    end

    // Request, scan tracking and result registers.
    always_ff @(posedge clk) begin
        rd_idx_reg <= cnt_reg;
        if (state_reg == ST_IDLE && req_valid) begin
            type_reg  <= req_type;
            pkey_reg  <= pkey;
            skey_reg  <= skey;
            ppres_reg <= ppres;
            spres_reg <= spres;
            nval_reg  <= nval;
            p_hit_reg <= 1'b0;
            pe_ok_reg <= 1'b0;
            s_hit_reg <= 1'b0;
            se_ok_reg <= 1'b0;
            fs_ok_reg <= 1'b0;
        end
        if (state_reg == ST_SCAN && rd_vld_reg) begin
            if (rd_idx_reg < CW'(PRIMARY_ENTRIES)) begin
                if (pri_used && pri_tag == pkey_reg && !p_hit_reg) begin
                    p_hit_reg  <= 1'b1;
                    p_ent_reg  <= rd_idx_reg[PW-1:0];
                    p_slot_reg <= pri_slot;
                end
                if (!pri_used && !pe_ok_reg) begin
                    pe_ok_reg  <= 1'b1;
                    pe_ent_reg <= rd_idx_reg[PW-1:0];
                end
            end
            if (rd_idx_reg < CW'(SECONDARY_ENTRIES)) begin
                if (sec_used && sec_tag == skey_reg && !s_hit_reg) begin
                    s_hit_reg  <= 1'b1;
                    s_slot_reg <= sec_slot;
                end
                if (!sec_used && !se_ok_reg) begin
                    se_ok_reg  <= 1'b1;
                    se_ent_reg <= rd_idx_reg[QW-1:0];
                end
            end
            if (rd_idx_reg < CW'(SLOTS) && slot_rc == '0 && !fs_ok_reg) begin
                fs_ok_reg <= 1'b1;
                fs_reg    <= rd_idx_reg[SW-1:0];
            end
        end
        if (state_reg == ST_DECIDE) begin
            status_reg   <= status_dec;
            value_reg    <= '0;
            tgt_slot_reg <= slot_addr;
        end
        if (state_reg == ST_SLOT_RD &&
            (type_reg == REQ_READ_PRI || type_reg == REQ_READ_SEC)) begin
            value_reg <= slot_rdata[VALUE_BITS-1:0];
        end
    end

    assign res.status     = status_reg;
    assign res.read_value = 32'(signed'(value_reg));
endmodule

>>> sv/dkrt_checker.sv
`include "dual_key_refcounted_table_defines.svh"

module dkrt_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import dkrt_pkg::*;

    // Reset empties the output and starts the clearing pass.
    `DKRT_ASSERT_ALWAYS(a_reset_quiet, !aresetn, !m_tvalid && !s_tready)
    // The sequencer works on one request at a time: the block is busy right after a request.
    `DKRT_ASSERT_NEXT(a_busy_after_req, s_tvalid && s_tready, !s_tready)
    // A failed request never carries a value.
    `DKRT_ASSERT_SAME(a_fail_zero, m_tvalid && m_tuser != STAT_OK, m_tdata == 32'd0)
    // A stalled result holds.
    `DKRT_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tuser))
endmodule

bind dual_key_refcounted_table dkrt_checker u_dkrt_checker (.*);
